// File: rtl/lbm_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and types of the D2Q9 collision pipeline.
package lbm_pkg;

   // fixed point format of the distribution values
   localparam int FRAC    = 28;
   localparam int Q_W     = 32;
   localparam int NDIR    = 9;
   localparam int MASK_W  = 8;
   localparam int OMEGA_W = 30;
   localparam int KEEP_W  = OMEGA_W + 1;
   localparam int WGT_W   = 32;

   // internal widths, all Q.28, sized to the largest reachable magnitude
   localparam int RHO_W  = 36;   // sum of nine values
   localparam int VEL_W  = 35;   // three minus three values
   localparam int DIAG_W = 36;   // vx +/- vy
   localparam int R3_W   = 34;   // rho / 3
   localparam int SQV_W  = 41;   // vx^2, vy^2
   localparam int SQD_W  = 43;   // (vx +/- vy)^2
   localparam int D_W    = 42;   // direction independent term
   localparam int G_W    = 43;   // 1.5 times a square
   localparam int TERM_W = 44;   // full direction term
   localparam int PK_W   = 35;   // (1 - omega) * f
   localparam int PW_W   = 47;   // weight * term
   localparam int SUM_W  = 48;

   // pipeline depth of one rounded fixed point multiply
   localparam int MUL_LAT = 4;

   // direction slots
   localparam int DIR_C  = 0;
   localparam int DIR_N  = 1;
   localparam int DIR_S  = 2;
   localparam int DIR_W  = 3;
   localparam int DIR_E  = 4;
   localparam int DIR_NW = 5;
   localparam int DIR_NE = 6;
   localparam int DIR_SW = 7;
   localparam int DIR_SE = 8;

   // relaxation weight slots
   localparam int NWGT       = 3;
   localparam int WGT_CENTER = 0;
   localparam int WGT_AXIS   = 1;
   localparam int WGT_DIAG   = 2;

   // Q.28 constants
   localparam logic [OMEGA_W-1:0] Q_ONE       = OMEGA_W'(268435456);
   localparam logic signed [Q_W-1:0] K_THIRD     = 32'sd89478485;
   localparam logic signed [Q_W-1:0] K_FOURTHIRD = 32'sd357913941;
   localparam logic signed [Q_W-1:0] K_TWELFTH   = 32'sd22369621;

   typedef logic signed [Q_W-1:0]    q_type;
   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic signed [WGT_W-1:0]  wgt_type;

   // control bits that travel with each item
   typedef struct packed {
      logic valid;
      logic fluid;
      logic row_end;
   } ctrl_type;

endpackage

// File: rtl/lbm_mulq.sv
`timescale 1ns / 1ps
// Pipelined signed Q.28 multiply, rounded to nearest with ties away from zero.
module lbm_mulq #(
   parameter int WA = 32,
   parameter int WB = 32,
   parameter int WR = 32
) (
   input  logic                 clock,
   input  logic signed [WA-1:0] a,
   input  logic signed [WB-1:0] b,
   output logic signed [WR-1:0] p
);
   import lbm_pkg::*;

   localparam int LA = WA / 2;
   localparam int HA = WA - LA;
   localparam int SW = (WA + WB + 1 > FRAC + WR) ? WA + WB + 1 : FRAC + WR;
   localparam logic [SW-1:0] RND = SW'(1) << (FRAC - 1);

   logic [WA-1:0]      a_u, ma_in, ma_ff;
   logic [WB-1:0]      b_u, mb_in, mb_ff;
   logic               neg_in;
   logic [2:0]         neg_ff;
   logic [LA+WB-1:0]   pp_lo_in, pp_lo_ff;
   logic [HA+WB-1:0]   pp_hi_in, pp_hi_ff;
   logic [SW-1:0]      sum;
   logic [WR-1:0]      mag_in, mag_ff;
   logic signed [WR-1:0] res_in, res_ff;

   // stage 1: magnitudes and result sign
   assign a_u    = a;
   assign b_u    = b;
   assign ma_in  = a_u[WA-1] ? (~a_u + WA'(1)) : a_u;
   assign mb_in  = b_u[WB-1] ? (~b_u + WB'(1)) : b_u;
   assign neg_in = a_u[WA-1] ^ b_u[WB-1];

   // stage 2: two partial products over the halves of a
   assign pp_lo_in = (LA+WB)'(ma_ff[LA-1:0]) * (LA+WB)'(mb_ff);
   assign pp_hi_in = (HA+WB)'(ma_ff[WA-1:LA]) * (HA+WB)'(mb_ff);

   // stage 3: combine, add half an lsb, drop the fraction
   assign sum    = (SW'(pp_hi_ff) << LA) + SW'(pp_lo_ff) + RND;
   assign mag_in = sum[FRAC +: WR];

   // stage 4: restore sign
   assign res_in = neg_ff[2] ? (~mag_ff + WR'(1)) : mag_ff;

   always_ff @(posedge clock) begin
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      neg_ff   <= {neg_ff[1:0], neg_in};
      pp_lo_ff <= pp_lo_in;
      pp_hi_ff <= pp_hi_in;
      mag_ff   <= mag_in;
      res_ff   <= res_in;
   end

   assign p = res_ff;

endmodule

// File: rtl/lbm_moments.sv
`timescale 1ns / 1ps
// Moment stages: density and velocity sums of one cell over four stages.
module lbm_moments (
   input  logic                               clock,
   input  logic                               reset,
   input  lbm_pkg::ctrl_type                  ctrl_in,
   input  lbm_pkg::q_type                     f_in [lbm_pkg::NDIR],
   output lbm_pkg::ctrl_type                  ctrl_out,
   output lbm_pkg::q_type                     f_out [lbm_pkg::NDIR],
   output logic signed [lbm_pkg::RHO_W-1:0]   rho,
   output logic signed [lbm_pkg::VEL_W-1:0]   vx,
   output logic signed [lbm_pkg::VEL_W-1:0]   vy,
   output logic signed [lbm_pkg::DIAG_W-1:0]  xmy,
   output logic signed [lbm_pkg::DIAG_W-1:0]  xpy
);
   import lbm_pkg::*;

   localparam int P_W = Q_W + 2;

   ctrl_type ctrl1_ff, ctrl2_ff, ctrl3_ff, ctrl4_ff;
   q_type    f1_ff [NDIR];
   q_type    f2_ff [NDIR];
   q_type    f3_ff [NDIR];
   q_type    f4_ff [NDIR];

   logic signed [P_W-1:0]    pe_in, pw_in, pn_in, ps_in;
   logic signed [P_W-1:0]    pe_ff, pw_ff, pn_ff, ps_ff;
   logic signed [RHO_W-1:0]  rho_in, rho3_ff, rho4_ff;
   logic signed [VEL_W-1:0]  vx_in, vy_in, vx3_ff, vy3_ff, vx4_ff, vy4_ff;
   logic signed [DIAG_W-1:0] xmy_in, xpy_in, xmy_ff, xpy_ff;

   // stage 2: three-term partial sums per side
   assign pe_in = P_W'(f1_ff[DIR_E]) + P_W'(f1_ff[DIR_NE]) + P_W'(f1_ff[DIR_SE]);
   assign pw_in = P_W'(f1_ff[DIR_W]) + P_W'(f1_ff[DIR_NW]) + P_W'(f1_ff[DIR_SW]);
   assign pn_in = P_W'(f1_ff[DIR_N]) + P_W'(f1_ff[DIR_NW]) + P_W'(f1_ff[DIR_NE]);
   assign ps_in = P_W'(f1_ff[DIR_S]) + P_W'(f1_ff[DIR_SW]) + P_W'(f1_ff[DIR_SE]);

   // stage 3: density and velocity
   assign rho_in = RHO_W'(f2_ff[DIR_C]) + RHO_W'(f2_ff[DIR_N]) + RHO_W'(f2_ff[DIR_S])
                 + RHO_W'(pe_ff) + RHO_W'(pw_ff);
   assign vx_in  = VEL_W'(pe_ff) - VEL_W'(pw_ff);
   assign vy_in  = VEL_W'(pn_ff) - VEL_W'(ps_ff);

   // stage 4: diagonal velocity combinations
   assign xmy_in = DIAG_W'(vx3_ff) - DIAG_W'(vy3_ff);
   assign xpy_in = DIAG_W'(vx3_ff) + DIAG_W'(vy3_ff);

   // item control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
         ctrl3_ff <= '0;
         ctrl4_ff <= '0;
      end else begin
         ctrl1_ff <= ctrl_in;
         ctrl2_ff <= ctrl1_ff;
         ctrl3_ff <= ctrl2_ff;
         ctrl4_ff <= ctrl3_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      f1_ff   <= f_in;
      f2_ff   <= f1_ff;
      f3_ff   <= f2_ff;
      f4_ff   <= f3_ff;
      pe_ff   <= pe_in;
      pw_ff   <= pw_in;
      pn_ff   <= pn_in;
      ps_ff   <= ps_in;
      rho3_ff <= rho_in;
      vx3_ff  <= vx_in;
      vy3_ff  <= vy_in;
      rho4_ff <= rho3_ff;
      vx4_ff  <= vx3_ff;
      vy4_ff  <= vy3_ff;
      xmy_ff  <= xmy_in;
      xpy_ff  <= xpy_in;
   end

   assign ctrl_out = ctrl4_ff;
   assign f_out    = f4_ff;
   assign rho      = rho4_ff;
   assign vx       = vx4_ff;
   assign vy       = vy4_ff;
   assign xmy      = xmy_ff;
   assign xpy      = xpy_ff;

endmodule

// File: rtl/lbm_equil.sv
`timescale 1ns / 1ps
// Equilibrium stages: squares of the velocity and the nine direction terms.
module lbm_equil (
   input  logic                               clock,
   input  logic                               reset,
   input  lbm_pkg::ctrl_type                  ctrl_in,
   input  lbm_pkg::q_type                     f_in [lbm_pkg::NDIR],
   input  logic signed [lbm_pkg::RHO_W-1:0]   rho,
   input  logic signed [lbm_pkg::VEL_W-1:0]   vx,
   input  logic signed [lbm_pkg::VEL_W-1:0]   vy,
   input  logic signed [lbm_pkg::DIAG_W-1:0]  xmy,
   input  logic signed [lbm_pkg::DIAG_W-1:0]  xpy,
   output lbm_pkg::ctrl_type                  ctrl_out,
   output lbm_pkg::q_type                     f_out [lbm_pkg::NDIR],
   output lbm_pkg::term_type                  term_out [lbm_pkg::NDIR]
);
   import lbm_pkg::*;

   // multiply, then four add stages
   localparam int F_DLY = MUL_LAT + 4;
   localparam int V_DLY = MUL_LAT + 3;

   ctrl_type ctrl_dly_ff [F_DLY];
   q_type    f_dly_ff    [F_DLY][NDIR];
   logic signed [VEL_W-1:0]  vx_dly_ff  [V_DLY];
   logic signed [VEL_W-1:0]  vy_dly_ff  [V_DLY];
   logic signed [DIAG_W-1:0] xmy_dly_ff [V_DLY];
   logic signed [DIAG_W-1:0] xpy_dly_ff [V_DLY];

   logic signed [SQV_W-1:0] xx_p, yy_p;
   logic signed [SQD_W-1:0] sq1_p, sq2_p;
   logic signed [R3_W-1:0]  r3_p;

   logic signed [SQV_W:0]   sxy_in, sxy_ff;
   logic signed [SQV_W-1:0] hx_in, hy_in, hx_ff, hy_ff, xx_ff, yy_ff;
   logic signed [SQD_W-1:0] h1_in, h2_in, h1_ff, h2_ff, sq1_ff, sq2_ff;
   logic signed [R3_W-1:0]  r3_ff;

   logic signed [D_W-1:0]   d_in, d10_ff, d11_ff;
   logic signed [G_W-1:0]   gx_in, gy_in, g1_in, g2_in, gx_ff, gy_ff, g1_ff, g2_ff;

   logic signed [TERM_W-1:0] tew_in, tns_in, tnwse_in, tnesw_in;
   logic signed [TERM_W-1:0] tew_ff, tns_ff, tnwse_ff, tnesw_ff;
   logic signed [TERM_W-1:0] vx_t, vy_t, xmy_t, xpy_t;
   term_type term_in [NDIR];
   term_type term_ff [NDIR];

   // squares and rho/3
   lbm_mulq #(.WA(VEL_W), .WB(VEL_W), .WR(SQV_W)) u_xx (
      .clock, .a(vx), .b(vx), .p(xx_p));
   lbm_mulq #(.WA(VEL_W), .WB(VEL_W), .WR(SQV_W)) u_yy (
      .clock, .a(vy), .b(vy), .p(yy_p));
   lbm_mulq #(.WA(DIAG_W), .WB(DIAG_W), .WR(SQD_W)) u_sq1 (
      .clock, .a(xmy), .b(xmy), .p(sq1_p));
   lbm_mulq #(.WA(DIAG_W), .WB(DIAG_W), .WR(SQD_W)) u_sq2 (
      .clock, .a(xpy), .b(xpy), .p(sq2_p));
   lbm_mulq #(.WA(RHO_W), .WB(Q_W), .WR(R3_W)) u_r3 (
      .clock, .a(rho), .b(K_THIRD), .p(r3_p));

   // squares are never negative: round(s/2) is (s+1)>>1, round(1.5s) is s + that
   assign sxy_in = (SQV_W+1)'(xx_p) + (SQV_W+1)'(yy_p) + (SQV_W+1)'(1);
   assign hx_in  = (xx_p + SQV_W'(1)) >>> 1;
   assign hy_in  = (yy_p + SQV_W'(1)) >>> 1;
   assign h1_in  = (sq1_p + SQD_W'(1)) >>> 1;
   assign h2_in  = (sq2_p + SQD_W'(1)) >>> 1;

   // direction independent term and the 1.5x squares
   assign d_in  = D_W'(r3_ff) - D_W'(sxy_ff >>> 1);
   assign gx_in = G_W'(xx_ff) + G_W'(hx_ff);
   assign gy_in = G_W'(yy_ff) + G_W'(hy_ff);
   assign g1_in = G_W'(sq1_ff) + G_W'(h1_ff);
   assign g2_in = G_W'(sq2_ff) + G_W'(h2_ff);

   // per-axis terms
   assign tew_in   = TERM_W'(d10_ff) + TERM_W'(gx_ff);
   assign tns_in   = TERM_W'(d10_ff) + TERM_W'(gy_ff);
   assign tnwse_in = TERM_W'(d10_ff) + TERM_W'(g1_ff);
   assign tnesw_in = TERM_W'(d10_ff) + TERM_W'(g2_ff);

   // final direction terms with the linear velocity part
   assign vx_t  = TERM_W'(vx_dly_ff[V_DLY-1]);
   assign vy_t  = TERM_W'(vy_dly_ff[V_DLY-1]);
   assign xmy_t = TERM_W'(xmy_dly_ff[V_DLY-1]);
   assign xpy_t = TERM_W'(xpy_dly_ff[V_DLY-1]);

   always_comb begin
      term_in[DIR_C]  = TERM_W'(d11_ff);
      term_in[DIR_N]  = tns_ff + vy_t;
      term_in[DIR_S]  = tns_ff - vy_t;
      term_in[DIR_W]  = tew_ff - vx_t;
      term_in[DIR_E]  = tew_ff + vx_t;
      term_in[DIR_NW] = tnwse_ff - xmy_t;
      term_in[DIR_NE] = tnesw_ff + xpy_t;
      term_in[DIR_SW] = tnesw_ff - xpy_t;
      term_in[DIR_SE] = tnwse_ff + xmy_t;
   end

   // item control delay
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < F_DLY; k++) ctrl_dly_ff[k] <= '0;
      end else begin
         ctrl_dly_ff[0] <= ctrl_in;
         for (int k = 1; k < F_DLY; k++) ctrl_dly_ff[k] <= ctrl_dly_ff[k-1];
      end
   end

   // payload delay lines
   always_ff @(posedge clock) begin
      f_dly_ff[0]   <= f_in;
      vx_dly_ff[0]  <= vx;
      vy_dly_ff[0]  <= vy;
      xmy_dly_ff[0] <= xmy;
      xpy_dly_ff[0] <= xpy;
      for (int k = 1; k < F_DLY; k++) f_dly_ff[k] <= f_dly_ff[k-1];
      for (int k = 1; k < V_DLY; k++) begin
         vx_dly_ff[k]  <= vx_dly_ff[k-1];
         vy_dly_ff[k]  <= vy_dly_ff[k-1];
         xmy_dly_ff[k] <= xmy_dly_ff[k-1];
         xpy_dly_ff[k] <= xpy_dly_ff[k-1];
      end
   end

   // arithmetic stages
   always_ff @(posedge clock) begin
      sxy_ff   <= sxy_in;
      hx_ff    <= hx_in;
      hy_ff    <= hy_in;
      h1_ff    <= h1_in;
      h2_ff    <= h2_in;
      xx_ff    <= xx_p;
      yy_ff    <= yy_p;
      sq1_ff   <= sq1_p;
      sq2_ff   <= sq2_p;
      r3_ff    <= r3_p;
      d10_ff   <= d_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      g1_ff    <= g1_in;
      g2_ff    <= g2_in;
      d11_ff   <= d10_ff;
      tew_ff   <= tew_in;
      tns_ff   <= tns_in;
      tnwse_ff <= tnwse_in;
      tnesw_ff <= tnesw_in;
      term_ff  <= term_in;
   end

   assign ctrl_out = ctrl_dly_ff[F_DLY-1];
   assign f_out    = f_dly_ff[F_DLY-1];
   assign term_out = term_ff;

endmodule

// File: rtl/lbm_relax.sv
`timescale 1ns / 1ps
// Relaxation stages: keep and weight products, sum, saturate, pass-through select.
module lbm_relax (
   input  logic                              clock,
   input  logic                              reset,
   input  lbm_pkg::ctrl_type                 ctrl_in,
   input  lbm_pkg::q_type                    f_in [lbm_pkg::NDIR],
   input  lbm_pkg::term_type                 term_in [lbm_pkg::NDIR],
   input  logic signed [lbm_pkg::KEEP_W-1:0] keep,
   input  lbm_pkg::wgt_type                  wgt [lbm_pkg::NWGT],
   output lbm_pkg::ctrl_type                 ctrl_out,
   output lbm_pkg::q_type                    res_out [lbm_pkg::NDIR]
);
   import lbm_pkg::*;

   ctrl_type ctrl_dly_ff [MUL_LAT];
   q_type    f_dly_ff    [MUL_LAT][NDIR];
   ctrl_type ctrl_out_ff;
   q_type    res_in [NDIR];
   q_type    res_ff [NDIR];

   logic signed [PK_W-1:0]  pk  [NDIR];
   logic signed [PW_W-1:0]  pw  [NDIR];
   logic signed [SUM_W-1:0] sum [NDIR];

   // clamp to the Q4.28 range
   function automatic q_type sat_q(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-Q_W:0] hi;
      hi = v[SUM_W-1:Q_W-1];
      if ((hi == '0) || (hi == '1)) begin
         sat_q = v[Q_W-1:0];
      end else if (v[SUM_W-1]) begin
         sat_q = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         sat_q = {1'b0, {(Q_W-1){1'b1}}};
      end
   endfunction

   // one keep product and one weighted term product per direction
   for (genvar i = 0; i < NDIR; i++) begin : g_dir
      localparam int WI = (i == DIR_C) ? WGT_CENTER : ((i <= DIR_E) ? WGT_AXIS : WGT_DIAG);

      lbm_mulq #(.WA(KEEP_W), .WB(Q_W), .WR(PK_W)) u_keep (
         .clock, .a(keep), .b(f_in[i]), .p(pk[i]));
      lbm_mulq #(.WA(TERM_W), .WB(WGT_W), .WR(PW_W)) u_wgt (
         .clock, .a(term_in[i]), .b(wgt[WI]), .p(pw[i]));
   end

   // sum and saturate; a cell that is not fluid passes through
   always_comb begin
      for (int i = 0; i < NDIR; i++) begin
         sum[i]    = SUM_W'(pk[i]) + SUM_W'(pw[i]);
         res_in[i] = ctrl_dly_ff[MUL_LAT-1].fluid ? sat_q(sum[i]) : f_dly_ff[MUL_LAT-1][i];
      end
   end

   // item control
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MUL_LAT; k++) ctrl_dly_ff[k] <= '0;
         ctrl_out_ff <= '0;
      end else begin
         ctrl_dly_ff[0] <= ctrl_in;
         for (int k = 1; k < MUL_LAT; k++) ctrl_dly_ff[k] <= ctrl_dly_ff[k-1];
         ctrl_out_ff <= ctrl_dly_ff[MUL_LAT-1];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      f_dly_ff[0] <= f_in;
      for (int k = 1; k < MUL_LAT; k++) f_dly_ff[k] <= f_dly_ff[k-1];
      res_ff <= res_in;
   end

   assign ctrl_out = ctrl_out_ff;
   assign res_out  = res_ff;

endmodule

// File: rtl/lbm_d2q9_srt_collide_cell.sv
`timescale 1ns / 1ps
// D2Q9 incompressible BGK collision of one lattice cell, fully pipelined.
// rsp_valid pulses for a cell once it has passed four moment stages, two chained
// 4-stage multiplies, four equilibrium add stages and the output register.
// Throughput: one cell per cycle; busy is never raised and results are not held.
// Reset (synchronous) empties the pipeline and sets fluid_mask to 1, omega to 1.0.
module lbm_d2q9_srt_collide_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_dist_center,
   input  logic signed [31:0] req_dist_north,
   input  logic signed [31:0] req_dist_south,
   input  logic signed [31:0] req_dist_west,
   input  logic signed [31:0] req_dist_east,
   input  logic signed [31:0] req_dist_northwest,
   input  logic signed [31:0] req_dist_northeast,
   input  logic signed [31:0] req_dist_southwest,
   input  logic signed [31:0] req_dist_southeast,
   input  logic [7:0]         req_cell_flags,
   input  logic               req_row_end,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_out_center,
   output logic signed [31:0] rsp_out_north,
   output logic signed [31:0] rsp_out_south,
   output logic signed [31:0] rsp_out_west,
   output logic signed [31:0] rsp_out_east,
   output logic signed [31:0] rsp_out_northwest,
   output logic signed [31:0] rsp_out_northeast,
   output logic signed [31:0] rsp_out_southwest,
   output logic signed [31:0] rsp_out_southeast,
   output logic               rsp_out_row_end,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [29:0]        csr_wdata
);
   import lbm_pkg::*;

   localparam logic [1:0]        CSR_FLUID_MASK = 2'd0;
   localparam logic [1:0]        CSR_RELAX_RATE = 2'd1;
   localparam logic [MASK_W-1:0] MASK_RESET     = MASK_W'(1);

   logic [MASK_W-1:0]        fluid_mask_ff, fluid_mask_in;
   logic [OMEGA_W-1:0]       relax_rate_ff, relax_rate_in;
   logic signed [KEEP_W-1:0] omega_s, keep_in, keep_ff;
   wgt_type                  wgt [NWGT];

   ctrl_type ctrl_in, ctrl_m, ctrl_e, ctrl_r;
   q_type    f_in  [NDIR];
   q_type    f_m   [NDIR];
   q_type    f_e   [NDIR];
   q_type    res   [NDIR];
   term_type term_e [NDIR];

   logic signed [RHO_W-1:0]  rho;
   logic signed [VEL_W-1:0]  vx, vy;
   logic signed [DIAG_W-1:0] xmy, xpy;

   // configuration registers
   always_comb begin
      fluid_mask_in = fluid_mask_ff;
      relax_rate_in = relax_rate_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FLUID_MASK: fluid_mask_in = csr_wdata[MASK_W-1:0];
            CSR_RELAX_RATE: relax_rate_in = csr_wdata[OMEGA_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fluid_mask_ff <= MASK_RESET;
         relax_rate_ff <= Q_ONE;
      end else begin
         fluid_mask_ff <= fluid_mask_in;
         relax_rate_ff <= relax_rate_in;
      end
   end

   // keep factor and weights follow omega; settled long before an item needs them
   assign omega_s = {1'b0, relax_rate_ff};
   assign keep_in = {1'b0, Q_ONE} - {1'b0, relax_rate_ff};

   always_ff @(posedge clock) begin
      keep_ff <= keep_in;
   end

   lbm_mulq #(.WA(KEEP_W), .WB(Q_W), .WR(WGT_W)) u_w0 (
      .clock, .a(omega_s), .b(K_FOURTHIRD), .p(wgt[WGT_CENTER]));
   lbm_mulq #(.WA(KEEP_W), .WB(Q_W), .WR(WGT_W)) u_w1 (
      .clock, .a(omega_s), .b(K_THIRD), .p(wgt[WGT_AXIS]));
   lbm_mulq #(.WA(KEEP_W), .WB(Q_W), .WR(WGT_W)) u_w2 (
      .clock, .a(omega_s), .b(K_TWELFTH), .p(wgt[WGT_DIAG]));

   // input item
   assign busy            = 1'b0;
   assign ctrl_in.valid   = start & ~busy;
   assign ctrl_in.fluid   = |(req_cell_flags & fluid_mask_ff);
   assign ctrl_in.row_end = req_row_end;

   assign f_in[DIR_C]  = req_dist_center;
   assign f_in[DIR_N]  = req_dist_north;
   assign f_in[DIR_S]  = req_dist_south;
   assign f_in[DIR_W]  = req_dist_west;
   assign f_in[DIR_E]  = req_dist_east;
   assign f_in[DIR_NW] = req_dist_northwest;
   assign f_in[DIR_NE] = req_dist_northeast;
   assign f_in[DIR_SW] = req_dist_southwest;
   assign f_in[DIR_SE] = req_dist_southeast;

   lbm_moments u_moments (
      .clock,
      .reset,
      .ctrl_in  (ctrl_in),
      .f_in     (f_in),
      .ctrl_out (ctrl_m),
      .f_out    (f_m),
      .rho      (rho),
      .vx       (vx),
      .vy       (vy),
      .xmy      (xmy),
      .xpy      (xpy)
   );

   lbm_equil u_equil (
      .clock,
      .reset,
      .ctrl_in  (ctrl_m),
      .f_in     (f_m),
      .rho      (rho),
      .vx       (vx),
      .vy       (vy),
      .xmy      (xmy),
      .xpy      (xpy),
      .ctrl_out (ctrl_e),
      .f_out    (f_e),
      .term_out (term_e)
   );

   lbm_relax u_relax (
      .clock,
      .reset,
      .ctrl_in  (ctrl_e),
      .f_in     (f_e),
      .term_in  (term_e),
      .keep     (keep_ff),
      .wgt      (wgt),
      .ctrl_out (ctrl_r),
      .res_out  (res)
   );

   // result item
   assign rsp_valid         = ctrl_r.valid;
   assign rsp_out_row_end   = ctrl_r.row_end;
   assign rsp_out_center    = res[DIR_C];
   assign rsp_out_north     = res[DIR_N];
   assign rsp_out_south     = res[DIR_S];
   assign rsp_out_west      = res[DIR_W];
   assign rsp_out_east      = res[DIR_E];
   assign rsp_out_northwest = res[DIR_NW];
   assign rsp_out_northeast = res[DIR_NE];
   assign rsp_out_southwest = res[DIR_SW];
   assign rsp_out_southeast = res[DIR_SE];

endmodule
